// ===== rtl/niwce_pkg.sv =====
// ----------------------------------------------------------------------------
// niwce_pkg
// Shared types and constants for the covariance estimator.
// ----------------------------------------------------------------------------
package niwce_pkg;
    localparam logic [1:0] KIND_SAMPLE  = 2'd0;
    localparam logic [1:0] KIND_RESTART = 2'd1;
    localparam logic [1:0] KIND_LOAD    = 2'd2;

    localparam logic [1:0] REG_KAPPA = 2'd0;
    localparam logic [1:0] REG_NU    = 2'd1;
    localparam logic [1:0] REG_PSI   = 2'd2;

    localparam int         CNT_W   = 24;
    localparam logic [23:0] CNT_MAX = 24'hFFFFFF;
    localparam logic signed [47:0] MAX48 = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] MIN48 = 48'sh8000_0000_0000;
    localparam logic signed [31:0] MAX32 = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] MIN32 = 32'sh8000_0000;

    // divider request / response
    typedef struct packed {
        logic         start;
        logic [111:0] num;
        logic [24:0]  den;
    } t_div_req;

    typedef struct packed {
        logic         busy;
        logic         done;
        logic [111:0] quo;
    } t_div_rsp;
endpackage

// ===== rtl/niwce_divider.sv =====
// ----------------------------------------------------------------------------
// niwce_divider
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module niwce_divider
    import niwce_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);
    logic [111:0] r_quo, n_quo;
    logic [24:0]  r_rem, n_rem;
    logic [24:0]  r_den;
    logic [6:0]   r_cnt;
    logic         r_busy, r_done;
    logic [25:0]  w_trial;

    always_comb begin
        w_trial = {r_rem, r_quo[111]} - {1'b0, r_den};
        n_quo   = {r_quo[110:0], ~w_trial[25]};
        n_rem   = w_trial[25] ? {r_rem[23:0], r_quo[111]} : w_trial[24:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 7'd0;
                r_quo  <= i_req.num;
                r_rem  <= '0;
                r_den  <= i_req.den;
            end else if (r_busy) begin
                r_quo <= n_quo;
                r_rem <= n_rem;
                r_cnt <= r_cnt + 7'd1;
                if (r_cnt == 7'd111) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

    a_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_den != '0) else $error("divider running with zero divisor");
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.done |-> $past(r_busy)) else $error("done without busy");
    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy) else $error("done while busy");
endmodule

// ===== rtl/niw_covariance_estimator.sv =====
// ----------------------------------------------------------------------------
// niw_covariance_estimator
// Sequential normal-inverse-Wishart mean and covariance estimator.
// ----------------------------------------------------------------------------
// channel  dir  handshake          payload
// in       in   i_valid/o_ready    kind, sample_0..3, entry_index, entry_value
// out      out  o_valid/i_ready    out_index, out_value, last
// cfg      in   apb                kappa_start, nu_start, psi_start_diag
// A sample runs, per scatter entry, a shift-add multiply and a divide in the
// shared serial divider, then one divide per mean and covariance entry, before
// the first output beat. Reset is synchronous and loads the priors.
// Input is not ready while busy; a stalled output beat holds the sequencer.
// ----------------------------------------------------------------------------
module niw_covariance_estimator
    import niwce_pkg::*;
#(
    parameter int DIM = 2
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_kind,
    input  logic signed [15:0] i_sample_0,
    input  logic signed [15:0] i_sample_1,
    input  logic signed [15:0] i_sample_2,
    input  logic signed [15:0] i_sample_3,
    input  logic [4:0]         i_entry_index,
    input  logic signed [47:0] i_entry_value,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [4:0]         o_out_index,
    output logic signed [47:0] o_out_value,
    output logic               o_last,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    localparam int NSQ = DIM * DIM;
    localparam int NE  = DIM + NSQ;
    localparam int IW  = (NSQ > 1) ? $clog2(NSQ) : 1;
    localparam int DW  = (DIM > 1) ? $clog2(DIM) : 1;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_SDIV = 3'd2;
    localparam logic [2:0] ST_MDIV = 3'd3;
    localparam logic [2:0] ST_CDIV = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;
    localparam logic [2:0] ST_MSET = 3'd6;

    logic [15:0] r_kappa_start, r_nu_start;
    logic [31:0] r_psi;
    logic signed [31:0] r_mean [DIM];
    logic signed [47:0] r_scat [NSQ];
    logic signed [47:0] r_cov  [NSQ];
    logic signed [33:0] r_d    [DIM];
    logic [CNT_W-1:0] r_kappa, r_nu;
    logic [2:0] r_state;
    logic [4:0] r_idx;
    logic [DW-1:0] r_row, r_col;
    logic [111:0] r_prod;
    logic [111:0] r_mc;
    logic [33:0]  r_mp;
    logic [5:0]   r_mcnt;
    logic         r_mph;
    logic [24:0]  r_den;
    logic         r_go, n_go;

    t_div_req w_req;
    t_div_rsp w_rsp;
    logic signed [15:0] w_smp [4];
    logic w_in_acc, w_wr;

    assign w_smp[0] = i_sample_0;
    assign w_smp[1] = i_sample_1;
    assign w_smp[2] = i_sample_2;
    assign w_smp[3] = i_sample_3;

    assign pready = 1'b1;
    assign w_wr = psel && penable && pwrite;
    always_comb begin
        unique case (paddr[3:2])
            REG_KAPPA: prdata = {16'd0, r_kappa_start};
            REG_NU:    prdata = {16'd0, r_nu_start};
            REG_PSI:   prdata = r_psi;
            default:   prdata = 32'd0;
        endcase
    end

    assign o_ready  = (r_state == ST_IDLE);
    assign w_in_acc = i_valid && o_ready;

    // entry under work, row and column of the scatter index
    logic [IW-1:0] w_ent;
    logic [DW-1:0] w_row, w_col;
    logic [33:0]   w_ai, w_aj;
    logic          w_neg;
    logic [24:0]   w_k1;
    assign w_ent = r_idx[IW-1:0];
    assign w_row = r_row;
    assign w_col = r_col;
    assign w_ai  = r_d[w_row][33] ? 34'(-r_d[w_row]) : 34'(r_d[w_row]);
    assign w_aj  = r_d[w_col][33] ? 34'(-r_d[w_col]) : 34'(r_d[w_col]);
    assign w_neg = r_d[w_row][33] ^ r_d[w_col][33];
    assign w_k1  = {1'b0, r_kappa} + 25'd1;

    // shift-add multiplier step
    logic [111:0] w_macc;
    assign w_macc = r_prod + (r_mp[0] ? r_mc : 112'd0);

    // signed views for the current divide
    logic [DW-1:0] w_mi;
    logic signed [33:0] w_dm;
    logic [47:0]  w_acov;
    assign w_mi   = r_idx[DW-1:0];
    assign w_dm   = r_d[w_mi];
    assign w_acov = r_scat[w_ent][47] ? 48'(-r_scat[w_ent]) : 48'(r_scat[w_ent]);

    logic signed [49:0] w_ssum;
    logic signed [34:0] w_msum;
    logic signed [49:0] w_q50;
    logic signed [33:0] w_q34;
    logic [CNT_W:0] w_nu1;
    logic signed [25:0] w_dv;
    assign w_q50  = w_neg ? 50'(-$signed({2'b00, w_rsp.quo[47:0]}))
                          : $signed({2'b00, w_rsp.quo[47:0]});
    assign w_ssum = 50'(r_scat[w_ent]) + w_q50;
    assign w_q34  = w_dm[33] ? 34'(-$signed(w_rsp.quo[33:0])) : $signed(w_rsp.quo[33:0]);
    assign w_msum = 35'(r_mean[w_mi]) + 35'(w_q34);
    assign w_nu1  = {1'b0, r_nu} + 25'd1;
    assign w_dv   = 26'($signed({2'b0, r_nu})) - 26'(DIM + 1);

    always_comb begin
        w_req.start = r_go;
        w_req.den   = r_den;
        w_req.num   = r_prod;
    end

    always_comb begin
        unique case (r_state)
            ST_MUL:  n_go = r_mph && (r_mcnt == 6'd23);
            ST_SDIV: n_go = w_rsp.done && (r_idx == 5'(NSQ - 1));
            ST_MDIV: n_go = w_rsp.done && (r_idx != 5'(DIM - 1));
            ST_CDIV: n_go = (r_den == '0) || (w_rsp.done && (r_idx != 5'(NSQ - 1)));
            default: n_go = 1'b0;
        endcase
    end

    niwce_divider u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_req), .o_rsp(w_rsp)
    );

    logic [47:0] w_diag;
    assign w_diag = r_psi[31] ? 48'(MAX48) : {r_psi, 16'd0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kappa_start <= '0;
            r_nu_start    <= '0;
            r_psi         <= 32'd3;
        end else if (w_wr) begin
            unique case (paddr[3:2])
                REG_KAPPA: r_kappa_start <= pwdata[15:0];
                REG_NU:    r_nu_start    <= pwdata[15:0];
                REG_PSI:   r_psi         <= pwdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_go    <= 1'b0;
            o_valid <= 1'b0;
            r_kappa <= '0;
            r_nu    <= '0;
            for (int i = 0; i < DIM; i++) r_mean[i] <= '0;
            for (int i = 0; i < NSQ; i++)
                r_scat[i] <= (i % (DIM + 1) == 0) ? 48'sd196608 : 48'sd0;
        end else begin
            r_go <= n_go;
            unique case (r_state)
                ST_IDLE: if (w_in_acc) begin
                    unique case (i_kind)
                        KIND_SAMPLE: begin
                            for (int i = 0; i < DIM; i++)
                                r_d[i] <= 34'($signed({w_smp[i], 16'd0})) - 34'(r_mean[i]);
                            r_idx   <= '0;
                            r_row   <= '0;
                            r_col   <= '0;
                            r_state <= ST_MSET;
                        end
                        KIND_RESTART: begin
                            for (int i = 0; i < DIM; i++) r_mean[i] <= '0;
                            for (int i = 0; i < NSQ; i++)
                                r_scat[i] <= (i % (DIM + 1) == 0) ? $signed(w_diag) : 48'sd0;
                            r_kappa <= CNT_W'(r_kappa_start);
                            r_nu    <= CNT_W'(r_nu_start);
                        end
                        KIND_LOAD: begin
                            if (i_entry_index < 5'(DIM)) begin
                                r_mean[i_entry_index[DW-1:0]] <=
                                    (i_entry_value > 48'(MAX32)) ? MAX32 :
                                    (i_entry_value < 48'(MIN32)) ? MIN32 :
                                    i_entry_value[31:0];
                            end else if (i_entry_index < 5'(NE)) begin
                                r_scat[IW'(i_entry_index - 5'(DIM))] <= i_entry_value;
                            end
                        end
                        default: ;
                    endcase
                end
                ST_MSET: begin
                    r_mc    <= 112'(w_ai);
                    r_mp    <= w_aj;
                    r_prod  <= '0;
                    r_mcnt  <= '0;
                    r_mph   <= 1'b0;
                    r_state <= ST_MUL;
                end
                ST_MUL: begin
                    // |di|*|dj| first, then times k, then down by 16
                    if (!r_mph && r_mcnt == 6'd33) begin
                        r_mc   <= w_macc;
                        r_mp   <= 34'(r_kappa);
                        r_prod <= '0;
                        r_mcnt <= '0;
                        r_mph  <= 1'b1;
                    end else if (r_mph && r_mcnt == 6'd23) begin
                        r_prod  <= w_macc >> 16;
                        r_den   <= w_k1;
                        r_state <= ST_SDIV;
                    end else begin
                        r_mc   <= r_mc << 1;
                        r_mp   <= r_mp >> 1;
                        r_prod <= w_macc;
                        r_mcnt <= r_mcnt + 6'd1;
                    end
                end
                ST_SDIV: if (w_rsp.done) begin
                    r_scat[w_ent] <= (w_ssum > 50'(MAX48)) ? MAX48 :
                                     (w_ssum < 50'(MIN48)) ? MIN48 : w_ssum[47:0];
                    if (r_idx == 5'(NSQ - 1)) begin
                        r_idx   <= '0;
                        r_prod  <= 112'(r_d[0][33] ? 34'(-r_d[0]) : 34'(r_d[0]));
                        r_state <= ST_MDIV;
                    end else begin
                        r_idx   <= r_idx + 5'd1;
                        if (r_col == DW'(DIM - 1)) begin
                            r_col <= '0;
                            r_row <= r_row + DW'(1);
                        end else begin
                            r_col <= r_col + DW'(1);
                        end
                        r_state <= ST_MSET;
                    end
                end
                ST_MDIV: if (w_rsp.done) begin
                    r_mean[w_mi] <= (w_msum > 35'(MAX32)) ? MAX32 :
                                    (w_msum < 35'(MIN32)) ? MIN32 : w_msum[31:0];
                    if (r_idx == 5'(DIM - 1)) begin
                        r_kappa <= (r_kappa == CNT_MAX) ? CNT_MAX : r_kappa + 24'd1;
                        r_nu    <= w_nu1[CNT_W] || (r_nu == CNT_MAX) ? CNT_MAX : w_nu1[23:0];
                        r_idx   <= '0;
                        r_state <= ST_CDIV;
                        r_den   <= '0;
                    end else begin
                        r_idx  <= r_idx + 5'd1;
                        r_prod <= 112'(r_d[DW'(r_idx + 5'd1)][33] ?
                                  34'(-r_d[DW'(r_idx + 5'd1)]) : 34'(r_d[DW'(r_idx + 5'd1)]));
                    end
                end
                ST_CDIV: begin
                    if (r_den == '0) begin
                        r_den  <= (w_dv > 0) ? w_dv[24:0] : 25'(r_nu) + 25'(DIM + 1);
                        r_prod <= 112'(w_acov);
                    end else if (w_rsp.done) begin
                        r_cov[w_ent] <= r_scat[w_ent][47] ?
                            48'(-$signed(w_rsp.quo[47:0])) : $signed(w_rsp.quo[47:0]);
                        if (r_idx == 5'(NSQ - 1)) begin
                            r_idx   <= '0;
                            o_valid <= 1'b1;
                            r_state <= ST_OUT;
                        end else begin
                            r_idx  <= r_idx + 5'd1;
                            r_prod <= {64'd0, (r_scat[IW'(r_idx + 5'd1)][47] ?
                                      48'(-r_scat[IW'(r_idx + 5'd1)]) :
                                      48'(r_scat[IW'(r_idx + 5'd1)]))};
                        end
                    end
                end
                ST_OUT: if (i_ready) begin
                    if (r_idx == 5'(NE - 1)) begin
                        o_valid <= 1'b0;
                        r_state <= ST_IDLE;
                    end else begin
                        r_idx <= r_idx + 5'd1;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_out_index = r_idx;
    assign o_last      = (r_idx == 5'(NE - 1));
    always_comb begin
        if (r_idx < 5'(DIM))
            o_out_value = 48'(r_mean[r_idx[DW-1:0]]);
        else
            o_out_value = r_cov[IW'(r_idx - 5'(DIM))];
    end

    a_valid_in_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_state == ST_OUT) else $error("valid outside output phase");
    a_not_ready_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> !w_rsp.busy) else $error("ready while divider busy");
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && o_last) |=> r_state == ST_IDLE)
        else $error("run did not end after last beat");
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_idx < 5'(NE)) else $error("output index out of range");
endmodule
